// ===== rtl/core/gdsc_pkg.sv =====
// Shared types and constants for the greedy-dual-size cache policy.
package gdsc_pkg;

  localparam int unsigned ENTRIES   = 32;
  localparam int unsigned FRAC_BITS = 40;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned PRIO_W    = 64;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_EVICT  = 2'd1;
  localparam logic [1:0] KIND_ADMIT  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic       REQ_LOOKUP = 1'b0;
  localparam logic       REQ_ADMIT  = 1'b1;

  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_INV   = 2'd1;
  localparam logic [1:0] MODE_FREQ  = 2'd2;
  localparam logic [1:0] MODE_PKT   = 2'd3;

  localparam logic [ADDR_W-1:0] REG_COST_MODE = 3'd0;
  localparam logic [ADDR_W-1:0] REG_CAPACITY  = 3'd4;

  localparam logic [1:0]  RESET_COST_MODE = 2'd2;
  localparam logic [31:0] RESET_CAPACITY  = 32'd1048576;
  localparam logic [31:0] PKT_BYTES       = 32'd536;

  // size / 536 = ((size >> 3) * PKT_RECIP) >> PKT_SHIFT, exact for all 32-bit sizes
  localparam logic [29:0] PKT_RECIP = 30'd1025663832;
  localparam int unsigned PKT_SHIFT = 36;

  typedef struct packed {
    logic        req_type;
    logic [31:0] object_id;
    logic [31:0] object_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        hit;
    logic [31:0] evicted_id;
    logic [31:0] evicted_size;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       id;
    logic [31:0]       size;
    logic [PRIO_W-1:0] prio;
    logic [31:0]       freq;
    logic [31:0]       order;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] size;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PRIO_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/gdsc_table.sv =====
// Entry table memory with registered read.
module gdsc_table (
  input  logic                      clk,
  input  logic                      we,
  input  logic [gdsc_pkg::IDX_W-1:0] waddr,
  input  gdsc_pkg::entry_t          wdata,
  input  logic [gdsc_pkg::IDX_W-1:0] raddr,
  output gdsc_pkg::entry_t          rdata
);
  import gdsc_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/gdsc_div.sv =====
// Bit-serial fixed-point cost divider: (num << FRAC_BITS) / size, saturating.
module gdsc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gdsc_pkg::div_req_t req,
  output gdsc_pkg::div_rsp_t rsp
);
  import gdsc_pkg::*;

  localparam int unsigned STEPS = 64 + FRAC_BITS;
  localparam int unsigned SC_W  = $clog2(STEPS + 1);

  logic [63:0]     num_r, num_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [STEPS-1:0] q_r, q_nxt;
  logic [31:0]     d_r, d_nxt;
  logic [SC_W-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [32:0]     shl;
  logic            ovf;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shl      = {rem_r[31:0], num_r[63]};
    if (req.start) begin
      num_nxt  = req.num;
      d_nxt    = (req.size == 32'd0) ? 32'd1 : req.size;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      if (shl >= {1'b0, d_r}) begin
        rem_nxt = shl - {1'b0, d_r};
        q_nxt   = {q_r[STEPS-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        q_nxt   = {q_r[STEPS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == SC_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign ovf      = |q_r[STEPS-1:PRIO_W];
  assign rsp.done = done_r;
  assign rsp.quot = ovf ? '1 : q_r[PRIO_W-1:0];
endmodule

// ===== rtl/core/gdsc_ctrl.sv =====
// Request sequencer: table scans, eviction, priority update and results.
module gdsc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  gdsc_pkg::req_t             in_req,
  output logic                       busy,
  output logic                       out_valid,
  output gdsc_pkg::rsp_t             out_rsp,
  input  logic [1:0]                 cost_mode,
  input  logic [31:0]                capacity,
  output logic                       tbl_we,
  output logic [gdsc_pkg::IDX_W-1:0] tbl_waddr,
  output gdsc_pkg::entry_t           tbl_wdata,
  output logic [gdsc_pkg::IDX_W-1:0] tbl_raddr,
  input  gdsc_pkg::entry_t           tbl_rdata,
  output gdsc_pkg::div_req_t         dreq,
  input  gdsc_pkg::div_rsp_t         drsp
);
  import gdsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FIND_END, S_CHECK, S_SCAN1, S_SCAN2, S_EVICT, S_RDV,
    S_COST, S_MUL, S_DIVW, S_WRITE
  } state_t;

  state_t            state_r;
  req_t              req_r;
  logic [ENTRIES-1:0] valid_r;
  logic [PRIO_W-1:0] clock_r;
  logic [31:0]       used_r, order_r;
  logic [CNT_W-1:0]  ptr_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_ok_r;
  logic              found_r;
  logic [IDX_W-1:0]  slot_r;
  logic              best_ok_r, sec_ok_r;
  logic [IDX_W-1:0]  best_r, sec_r;
  logic [PRIO_W-1:0] best_prio_r;
  logic [31:0]       best_age_r, best_size_r, sec_age_r, sec_size_r;
  entry_t            ent_r;
  logic [31:0]       num_a_r;
  logic [31:0]       num_b_r;
  logic [63:0]       num_r;
  logic              out_valid_r;
  rsp_t              out_rsp_r;
  logic              we_r;
  logic [IDX_W-1:0]  waddr_r;
  entry_t            wdata_r;
  logic              dstart_r;

  logic              free_ok;
  logic [IDX_W-1:0]  free_idx;
  logic [32:0]       need;
  logic [31:0]       age;
  logic [PRIO_W:0]   psum;
  logic              scan_done;
  logic [58:0]       pkt_prod;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign need      = {1'b0, used_r} + {1'b0, req_r.object_size};
  assign age       = order_r - tbl_rdata.order;
  assign psum      = {1'b0, clock_r} + {1'b0, drsp.quot};
  assign scan_done = (ptr_r == CNT_W'(ENTRIES));
  assign busy      = (state_r != S_IDLE);
  assign tbl_raddr = ptr_r[IDX_W-1:0];
  assign pkt_prod  = {30'd0, ent_r.size[31:3]} * {29'd0, PKT_RECIP};

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    we_r        <= 1'b0;
    dstart_r    <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      clock_r <= '0;
      used_r  <= '0;
      order_r <= '0;
      ptr_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r  <= 1'b0;
      rd_idx_r <= ptr_r[IDX_W-1:0];
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= in_req;
            ptr_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_FIND;
          end
        end
        S_FIND: begin
          if (rd_ok_r && valid_r[rd_idx_r] && tbl_rdata.id == req_r.object_id
              && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= rd_idx_r;
            ent_r   <= tbl_rdata;
          end
          if (scan_done) begin
            state_r <= S_FIND_END;
          end else begin
            ptr_r   <= ptr_r + 1'b1;
            rd_ok_r <= 1'b1;
          end
        end
        S_FIND_END: begin
          if (rd_ok_r && valid_r[rd_idx_r] && tbl_rdata.id == req_r.object_id
              && !found_r) begin
            found_r <= 1'b1;
            slot_r  <= rd_idx_r;
            ent_r   <= tbl_rdata;
          end
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (req_r.req_type == REQ_LOOKUP) begin
            if (found_r) begin
              ent_r.freq  <= (ent_r.freq == '1) ? ent_r.freq : ent_r.freq + 1'b1;
              ent_r.order <= order_r;
              order_r     <= order_r + 1'b1;
              state_r     <= S_COST;
            end else begin
              out_valid_r <= 1'b1;
              out_rsp_r   <= '{KIND_LOOKUP, 1'b0, 32'd0, 32'd0, 1'b1};
              state_r     <= S_IDLE;
            end
          end else if (req_r.object_size > capacity || found_r) begin
            out_valid_r <= 1'b1;
            out_rsp_r   <= '{KIND_REJECT, 1'b0, 32'd0, 32'd0, 1'b1};
            state_r     <= S_IDLE;
          end else if (free_ok && need <= {1'b0, capacity}) begin
            slot_r      <= free_idx;
            ent_r.id    <= req_r.object_id;
            ent_r.size  <= req_r.object_size;
            ent_r.freq  <= 32'd1;
            ent_r.order <= order_r;
            order_r     <= order_r + 1'b1;
            state_r     <= S_COST;
          end else if (valid_r == '0) begin
            slot_r      <= free_ok ? free_idx : '0;
            ent_r.id    <= req_r.object_id;
            ent_r.size  <= req_r.object_size;
            ent_r.freq  <= 32'd1;
            ent_r.order <= order_r;
            order_r     <= order_r + 1'b1;
            state_r     <= S_COST;
          end else begin
            ptr_r     <= '0;
            best_ok_r <= 1'b0;
            state_r   <= S_SCAN1;
          end
        end
        S_SCAN1: begin
          if (rd_ok_r && valid_r[rd_idx_r]) begin
            if (!best_ok_r || tbl_rdata.prio < best_prio_r ||
                (tbl_rdata.prio == best_prio_r && age > best_age_r)) begin
              best_ok_r   <= 1'b1;
              best_r      <= rd_idx_r;
              best_prio_r <= tbl_rdata.prio;
              best_age_r  <= age;
              best_size_r <= tbl_rdata.size;
            end
          end
          if (scan_done && !rd_ok_r) begin
            ptr_r    <= '0;
            sec_ok_r <= 1'b0;
            state_r  <= S_SCAN2;
          end else if (!scan_done) begin
            ptr_r   <= ptr_r + 1'b1;
            rd_ok_r <= 1'b1;
          end
        end
        S_SCAN2: begin
          if (rd_ok_r && valid_r[rd_idx_r] && rd_idx_r != best_r &&
              tbl_rdata.prio == best_prio_r) begin
            if (!sec_ok_r || age > sec_age_r) begin
              sec_ok_r   <= 1'b1;
              sec_r      <= rd_idx_r;
              sec_age_r  <= age;
              sec_size_r <= tbl_rdata.size;
            end
          end
          if (scan_done && !rd_ok_r) begin
            state_r <= S_EVICT;
          end else if (!scan_done) begin
            ptr_r   <= ptr_r + 1'b1;
            rd_ok_r <= 1'b1;
          end
        end
        S_EVICT: begin
          ptr_r   <= {1'b0, (sec_ok_r && sec_size_r > best_size_r) ? sec_r : best_r};
          state_r <= S_RDV;
          rd_ok_r <= 1'b1;
        end
        S_RDV: begin
          if (rd_ok_r) begin
            rd_ok_r <= 1'b0;
          end else begin
            clock_r              <= tbl_rdata.prio;
            used_r               <= (used_r >= tbl_rdata.size) ?
                                    used_r - tbl_rdata.size : 32'd0;
            valid_r[rd_idx_r]    <= 1'b0;
            out_valid_r          <= 1'b1;
            out_rsp_r            <= '{KIND_EVICT, 1'b0, tbl_rdata.id, tbl_rdata.size,
                                      1'b0};
            state_r              <= S_CHECK;
          end
          rd_idx_r <= rd_idx_r;
          if (rd_ok_r) begin
            rd_idx_r <= ptr_r[IDX_W-1:0];
          end
        end
        S_COST: begin
          num_a_r <= (cost_mode == MODE_INV) ? 32'd1 : ent_r.freq;
          num_b_r <= (cost_mode == MODE_PKT) ?
                     32'd2 + {9'd0, pkt_prod[58:PKT_SHIFT]} : 32'd1;
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r <= 64'(num_a_r) * 64'(num_b_r);
          if (cost_mode == MODE_CONST) begin
            state_r <= S_WRITE;
          end else begin
            dstart_r <= 1'b1;
            state_r  <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            ent_r.prio <= psum[PRIO_W] ? '1 : psum[PRIO_W-1:0];
            state_r    <= S_WRITE;
          end
        end
        S_WRITE: begin
          we_r    <= 1'b1;
          waddr_r <= slot_r;
          wdata_r <= ent_r;
          if (cost_mode == MODE_CONST) begin
            wdata_r.prio <= (clock_r > ~(PRIO_W'(1) << FRAC_BITS)) ? '1 :
                            clock_r + (PRIO_W'(1) << FRAC_BITS);
          end
          out_valid_r <= 1'b1;
          if (req_r.req_type == REQ_LOOKUP) begin
            out_rsp_r <= '{KIND_LOOKUP, 1'b1, 32'd0, 32'd0, 1'b1};
          end else begin
            valid_r[slot_r] <= 1'b1;
            used_r          <= used_r + req_r.object_size;
            out_rsp_r       <= '{KIND_ADMIT, 1'b0, 32'd0, 32'd0, 1'b1};
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign tbl_we    = we_r;
  assign tbl_waddr = waddr_r;
  assign tbl_wdata = wdata_r;
  assign dreq      = '{dstart_r, num_r, ent_r.size};
endmodule

// ===== rtl/core/greedy_dual_size_cache_policy.sv =====
// Greedy-dual-size cache policy top level: register port, sequencer, table, divider.
//   channel | handshake        | payload
//   in_     | start / busy     | in_req (req_t)
//   out_    | out_valid strobe | out_rsp (rsp_t)
//   cfg_    | APB write/read   | cost_mode @0, capacity_bytes @4
// A lookup miss or reject holds busy for one table scan; a hit or
// admit adds the 104-step serial divider (skipped in constant mode).
// Each eviction adds two table scans and a victim read.
// Reset clears valid bits, aging clock, byte count and order counter at once.
// Results go out as one-cycle strobes; the receiver cannot stall them.
module greedy_dual_size_cache_policy (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gdsc_pkg::req_t                in_req,
  output logic                          out_valid,
  output gdsc_pkg::rsp_t                out_rsp,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gdsc_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import gdsc_pkg::*;

  logic [1:0]       mode_r;
  logic [31:0]      cap_r;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
  entry_t           tbl_wdata, tbl_rdata;
  div_req_t         dreq;
  div_rsp_t         drsp;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RESET_COST_MODE;
      cap_r  <= RESET_CAPACITY;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        REG_COST_MODE: mode_r <= cfg_pwdata[1:0];
        REG_CAPACITY:  cap_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_COST_MODE: cfg_prdata = {30'd0, mode_r};
      REG_CAPACITY:  cfg_prdata = cap_r;
      default:       cfg_prdata = 32'd0;
    endcase
  end

  gdsc_table u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  gdsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  gdsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_req(in_req), .busy(busy),
    .out_valid(out_valid), .out_rsp(out_rsp), .cost_mode(mode_r),
    .capacity(cap_r), .tbl_we(tbl_we), .tbl_waddr(tbl_waddr),
    .tbl_wdata(tbl_wdata), .tbl_raddr(tbl_raddr), .tbl_rdata(tbl_rdata),
    .dreq(dreq), .drsp(drsp)
  );

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.last |-> !busy) else $error("busy during last result");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.kind == KIND_EVICT |-> !out_rsp.last)
    else $error("eviction marked last");
endmodule
